### rtl/core/adss_pkg.sv
// Shared types and constants for the axis dead-zone / saturation scaler.
`timescale 1ns / 1ps

package adss_pkg;

   // Configuration port geometry
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REG_W      = 14;

   typedef enum logic [0:0] {
      REG_DEADZONE   = 1'b0,
      REG_SATURATION = 1'b1
   } adss_reg_type;

   localparam logic [REG_W-1:0] DEADZONE_RESET   = 14'd0;
   localparam logic [REG_W-1:0] SATURATION_RESET = 14'd10000;

   // Sample and result widths
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned EDGE_W   = 16;
   localparam int unsigned SCALED_W = 16;

   // Physical range
   localparam logic [SCALED_W-1:0] PHY_MIN    = 16'd0;
   localparam logic [SCALED_W-1:0] PHY_CENTRE = 16'd32767;
   localparam logic [SCALED_W-1:0] PHY_MAX    = 16'd65535;

   // Edge computation: x / 10000 via reciprocal, x below 2^30
   localparam int unsigned EDGE_X_W    = 30;
   localparam int unsigned RECIP_W     = 27;
   localparam int unsigned RECIP_SHIFT = 40;
   localparam int unsigned PROD_W      = EDGE_X_W + RECIP_W;
   localparam logic [RECIP_W-1:0]  EDGE_RECIP  = 27'd109951162;
   localparam logic [EDGE_X_W-1:0] SCALE_UNITS = 30'd10000;
   localparam logic [EDGE_X_W-1:0] SCALE_HALF  = 30'd5000;

   // Divider chain
   localparam int unsigned DIV_STEPS = 16;
   localparam int unsigned REM_W     = 17;
   localparam int unsigned DVD_W     = REM_W + DIV_STEPS;

   // Data moved from one divider cell to the next
   typedef struct packed {
      logic                 centre;
      logic                 sat;
      logic                 pos;
      logic [REM_W-1:0]     rem;
      logic [REM_W-1:0]     divisor;
      logic [DIV_STEPS-1:0] dlow;
      logic [DIV_STEPS-1:0] quot;
   } adss_cell_type;

endpackage

### rtl/core/axis_deadzone_saturation_scaler_unit.sv
// Pipeline: an accepted request beat passes 4 front stages, 16 division cells and 1
// output register on its way to its response beat. Throughput: one beat per cycle while
// rsp_ready does not stall the output; the 16-cell divider chain is fully pipelined and each stage stalls on its own.
// Reset (synchronous, active high) empties every stage, sets dead zone to 0 and
// saturation to 10000.
`timescale 1ns / 1ps

module axis_deadzone_saturation_scaler_unit import adss_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_axis_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [SCALED_W-1:0]        rsp_scaled_value,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [CSR_DATA_W-1:0]      csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic [REG_W-1:0] deadzone;
   logic [REG_W-1:0] saturation;

   logic          link_valid [DIV_STEPS+1];
   logic          link_ready [DIV_STEPS+1];
   adss_cell_type link_data  [DIV_STEPS+1];

   logic                rsp_valid_ff;
   logic [SCALED_W-1:0] rsp_value_ff;
   logic [SCALED_W-1:0] rsp_value_in;
   logic                out_rdy;
   adss_cell_type       last;

   adss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .deadzone    (deadzone),
      .saturation  (saturation)
   );

   adss_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_axis_value (req_axis_value),
      .deadzone       (deadzone),
      .saturation     (saturation),
      .out_valid      (link_valid[0]),
      .out_ready      (link_ready[0]),
      .out_data       (link_data[0])
   );

   // Divider chain, one quotient bit per cell
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      adss_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   // Output register: pick center, range end or the interpolated value
   assign out_rdy                = !rsp_valid_ff || rsp_ready;
   assign link_ready[DIV_STEPS]  = out_rdy;
   assign last                   = link_data[DIV_STEPS];

   always_comb begin
      if (last.centre) begin
         rsp_value_in = PHY_CENTRE;
      end else if (last.sat) begin
         rsp_value_in = last.pos ? PHY_MAX : PHY_MIN;
      end else if (last.pos) begin
         rsp_value_in = SCALED_W'((SCALED_W+1)'(PHY_CENTRE) + (SCALED_W+1)'(last.quot));
      end else begin
         rsp_value_in = last.quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= link_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && link_valid[DIV_STEPS]) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scaled_value = rsp_value_ff;

endmodule

### rtl/core/adss_csr.sv
// Configuration registers (dead zone, saturation) behind the APB-style port.
`timescale 1ns / 1ps

module adss_csr import adss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [REG_W-1:0]      deadzone,
   output logic [REG_W-1:0]      saturation
);

   logic [REG_W-1:0] deadzone_ff;
   logic [REG_W-1:0] saturation_ff;
   logic             wr_en;
   adss_reg_type     reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = adss_reg_type'(csr_paddr[2]);

   // Write the addressed register in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff   <= DEADZONE_RESET;
         saturation_ff <= SATURATION_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            REG_DEADZONE:   deadzone_ff   <= csr_pwdata[REG_W-1:0];
            REG_SATURATION: saturation_ff <= csr_pwdata[REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Return the addressed register, zero extended
   always_comb begin
      case (reg_sel)
         REG_DEADZONE:   csr_prdata = CSR_DATA_W'(deadzone_ff);
         REG_SATURATION: csr_prdata = CSR_DATA_W'(saturation_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign deadzone   = deadzone_ff;
   assign saturation = saturation_ff;

endmodule

### rtl/core/adss_front.sv
// Front stages: center the sample, derive the side's edges, classify, build the dividend.
`timescale 1ns / 1ps

module adss_front import adss_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_axis_value,
   input  logic [REG_W-1:0]           deadzone,
   input  logic [REG_W-1:0]           saturation,
   output logic                       out_valid,
   input  logic                       out_ready,
   output adss_cell_type              out_data
);

   localparam int unsigned NSTAGE = 4;

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;
   logic [NSTAGE-1:0] stage_rdy;

   // Stage A: magnitude, side and rounded edge numerators
   logic [EDGE_W-1:0]   a_mag_ff;
   logic                a_pos_ff;
   logic [EDGE_X_W-1:0] a_xd_ff;
   logic [EDGE_X_W-1:0] a_xs_ff;
   // Stage B: reciprocal estimates
   logic [EDGE_W-1:0]   b_mag_ff;
   logic                b_pos_ff;
   logic [EDGE_X_W-1:0] b_xd_ff;
   logic [EDGE_X_W-1:0] b_xs_ff;
   logic [EDGE_W-1:0]   b_qd_ff;
   logic [EDGE_W-1:0]   b_qs_ff;
   // Stage C: exact edges
   logic [EDGE_W-1:0]   c_mag_ff;
   logic                c_pos_ff;
   logic [EDGE_W-1:0]   c_lo_ff;
   logic [EDGE_W-1:0]   c_hi_ff;
   // Stage D: first cell input
   adss_cell_type       d_data_ff;

   logic [SAMPLE_W:0]   v_cent;
   logic [SAMPLE_W:0]   v_neg;
   logic                v_pos;
   logic [EDGE_W-1:0]   v_mag;
   logic [EDGE_X_W-1:0] xd_in;
   logic [EDGE_X_W-1:0] xs_in;
   logic [PROD_W-1:0]   prod_d;
   logic [PROD_W-1:0]   prod_s;
   logic [EDGE_X_W-1:0] rem_d;
   logic [EDGE_X_W-1:0] rem_s;
   logic [EDGE_W-1:0]   lo_in;
   logic [EDGE_W-1:0]   hi_in;
   logic [EDGE_W-1:0]   span;
   logic [EDGE_W-1:0]   offs;
   logic [30:0]         offs_k;
   logic [DVD_W-1:0]    dvd;
   adss_cell_type       d_data_in;

   // Hold a stage while its successor is full and stalled
   assign stage_rdy[NSTAGE-1] = !valid_ff[NSTAGE-1] || out_ready;
   for (genvar i = 0; i < NSTAGE - 1; i++) begin : g_rdy
      assign stage_rdy[i] = !valid_ff[i] || stage_rdy[i+1];
   end

   assign valid_in[0] = stage_rdy[0] ? req_valid : valid_ff[0];
   for (genvar i = 1; i < NSTAGE; i++) begin : g_vld
      assign valid_in[i] = stage_rdy[i] ? valid_ff[i-1] : valid_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Center on the logical center and split into side and magnitude
   assign v_cent = {req_axis_value[SAMPLE_W-1], req_axis_value} + 17'd1;
   assign v_neg  = 17'd0 - v_cent;
   assign v_pos  = !v_cent[SAMPLE_W] && (v_cent != 17'd0);
   assign v_mag  = v_pos ? v_cent[EDGE_W-1:0] : v_neg[EDGE_W-1:0];

   // Half range is 32768 above center and 32767 below
   assign xd_in = EDGE_X_W'({deadzone, 15'd0})
                  - (v_pos ? '0 : EDGE_X_W'(deadzone)) + SCALE_HALF;
   assign xs_in = EDGE_X_W'({saturation, 15'd0})
                  - (v_pos ? '0 : EDGE_X_W'(saturation)) + SCALE_HALF;

   always_ff @(posedge clock) begin
      if (stage_rdy[0] && req_valid) begin
         a_mag_ff <= v_mag;
         a_pos_ff <= v_pos;
         a_xd_ff  <= xd_in;
         a_xs_ff  <= xs_in;
      end
   end

   // Estimate x / 10000, low by at most one
   assign prod_d = PROD_W'(a_xd_ff) * PROD_W'(EDGE_RECIP);
   assign prod_s = PROD_W'(a_xs_ff) * PROD_W'(EDGE_RECIP);

   always_ff @(posedge clock) begin
      if (stage_rdy[1] && valid_ff[0]) begin
         b_mag_ff <= a_mag_ff;
         b_pos_ff <= a_pos_ff;
         b_xd_ff  <= a_xd_ff;
         b_xs_ff  <= a_xs_ff;
         b_qd_ff  <= prod_d[RECIP_SHIFT +: EDGE_W];
         b_qs_ff  <= prod_s[RECIP_SHIFT +: EDGE_W];
      end
   end

   // Correct the estimate with one compare
   assign rem_d = b_xd_ff - EDGE_X_W'(EDGE_X_W'(b_qd_ff) * SCALE_UNITS);
   assign rem_s = b_xs_ff - EDGE_X_W'(EDGE_X_W'(b_qs_ff) * SCALE_UNITS);
   assign lo_in = b_qd_ff + EDGE_W'(rem_d >= SCALE_UNITS);
   assign hi_in = b_qs_ff + EDGE_W'(rem_s >= SCALE_UNITS);

   always_ff @(posedge clock) begin
      if (stage_rdy[2] && valid_ff[1]) begin
         c_mag_ff <= b_mag_ff;
         c_pos_ff <= b_pos_ff;
         c_lo_ff  <= lo_in;
         c_hi_ff  <= hi_in;
      end
   end

   // Classify and form 2*n*K + span over 2*span for the rounded quotient
   assign span   = c_hi_ff - c_lo_ff;
   assign offs   = c_pos_ff ? (c_mag_ff - c_lo_ff) : (c_hi_ff - c_mag_ff);
   assign offs_k = {offs, 15'd0} - (c_pos_ff ? 31'd0 : 31'(offs));
   assign dvd    = DVD_W'({offs_k, 1'b0}) + DVD_W'(span);

   always_comb begin
      d_data_in.centre  = c_mag_ff <= c_lo_ff;
      d_data_in.sat     = c_mag_ff >= c_hi_ff;
      d_data_in.pos     = c_pos_ff;
      d_data_in.rem     = dvd[DVD_W-1 -: REM_W];
      d_data_in.divisor = {span, 1'b0};
      d_data_in.dlow    = dvd[DIV_STEPS-1:0];
      d_data_in.quot    = '0;
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[3] && valid_ff[2]) begin
         d_data_ff <= d_data_in;
      end
   end

   assign req_ready = stage_rdy[0];
   assign out_valid = valid_ff[NSTAGE-1];
   assign out_data  = d_data_ff;

endmodule

### rtl/core/adss_div_cell.sv
// One restoring-division cell: develops one quotient bit and hands on the remainder.
`timescale 1ns / 1ps

module adss_div_cell import adss_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  adss_cell_type in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output adss_cell_type out_data
);

   logic          valid_ff;
   adss_cell_type data_ff;
   adss_cell_type data_in;
   logic [REM_W:0] trial;
   logic           take;

   assign in_ready = !valid_ff || out_ready;

   // Shift in the next dividend bit and subtract where it fits
   assign trial = {in_data.rem, in_data.dlow[DIV_STEPS-1]};
   assign take  = trial >= (REM_W+1)'(in_data.divisor);

   always_comb begin
      data_in      = in_data;
      data_in.rem  = take ? REM_W'(trial - (REM_W+1)'(in_data.divisor)) : trial[REM_W-1:0];
      data_in.dlow = {in_data.dlow[DIV_STEPS-2:0], 1'b0};
      data_in.quot = {in_data.quot[DIV_STEPS-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
